FILE: rtl/wwgs_pkg.sv
// shared constants, codes and types for the wireworld grid step core
package wwgs_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WD_W     = $clog2(MAX_WIDTH + 1);
    localparam int HD_W     = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_BITS = 2 * MAX_WIDTH;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] WW_BLANK = 2'd0;
    localparam logic [1:0] WW_HEAD  = 2'd1;
    localparam logic [1:0] WW_TAIL  = 2'd2;
    localparam logic [1:0] WW_WIRE  = 2'd3;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_MOD,
        ST_STEP_RD,
        ST_STEP_SHIFT,
        ST_STEP_WB,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]       we;
        logic [ROW_W-1:0] waddr;
        logic [ROW_W-1:0] raddr;
        logic             rsel;
    } mem_req_t;

    typedef struct packed {
        logic load_up;
        logic load_mid;
        logic load_dn;
        logic shift;
        logic first;
        logic right_ok;
        logic in_grid;
    } eng_ctrl_t;

endpackage

FILE: rtl/wwgs_grid_mem.sv
// two row-wide grid banks with one write and one registered read port each
module wwgs_grid_mem (
    input  logic                          clk,
    input  wwgs_pkg::mem_req_t            req,
    input  logic [wwgs_pkg::ROW_BITS-1:0] wdata,
    output logic [wwgs_pkg::ROW_BITS-1:0] rdata
);
    import wwgs_pkg::*;

    logic [ROW_BITS-1:0] bank_a [MAX_HEIGHT];
    logic [ROW_BITS-1:0] bank_b [MAX_HEIGHT];
    logic [ROW_BITS-1:0] rd_a_reg;
    logic [ROW_BITS-1:0] rd_b_reg;
    logic                rsel_reg;

    always_ff @(posedge clk)
    begin
        if (req.we[0])
        begin
            bank_a[req.waddr] <= wdata;
        end
        if (req.we[1])
        begin
            bank_b[req.waddr] <= wdata;
        end
        rd_a_reg <= bank_a[req.raddr];
        rd_b_reg <= bank_b[req.raddr];
        rsel_reg <= req.rsel;
    end

    assign rdata = rsel_reg ? rd_b_reg : rd_a_reg;

endmodule

FILE: rtl/wwgs_row_engine.sv
// three-row window shifter that applies the cell rule one cell per cycle while shift is set
module wwgs_row_engine (
    input  logic                          clk,
    input  wwgs_pkg::eng_ctrl_t           ctrl,
    input  logic [wwgs_pkg::ROW_BITS-1:0] rdata,
    output logic [wwgs_pkg::ROW_BITS-1:0] out_row
);
    import wwgs_pkg::*;

    logic [ROW_BITS-1:0] sh_up_reg;
    logic [ROW_BITS-1:0] sh_mid_reg;
    logic [ROW_BITS-1:0] sh_dn_reg;
    logic [ROW_BITS-1:0] out_reg;
    logic [1:0]          prev_up_reg;
    logic [1:0]          prev_mid_reg;
    logic [1:0]          prev_dn_reg;

    logic [1:0] c_up, c_mid, c_dn;
    logic [1:0] l_up, l_mid, l_dn;
    logic [1:0] r_up, r_mid, r_dn;
    logic [7:0] head_hits;
    logic [3:0] heads;
    logic [1:0] nv;

    always_comb
    begin
        c_up  = sh_up_reg[1:0];
        c_mid = sh_mid_reg[1:0];
        c_dn  = sh_dn_reg[1:0];
        l_up  = ctrl.first ? c_up  : prev_up_reg;
        l_mid = ctrl.first ? c_mid : prev_mid_reg;
        l_dn  = ctrl.first ? c_dn  : prev_dn_reg;
        r_up  = ctrl.right_ok ? sh_up_reg[3:2]  : c_up;
        r_mid = ctrl.right_ok ? sh_mid_reg[3:2] : c_mid;
        r_dn  = ctrl.right_ok ? sh_dn_reg[3:2]  : c_dn;
        head_hits = {l_up == WW_HEAD, c_up == WW_HEAD, r_up == WW_HEAD,
                     l_mid == WW_HEAD, r_mid == WW_HEAD,
                     l_dn == WW_HEAD, c_dn == WW_HEAD, r_dn == WW_HEAD};
        heads = 4'($countones(head_hits));
        case (c_mid)
            WW_HEAD: nv = WW_TAIL;
            WW_TAIL: nv = WW_WIRE;
            WW_WIRE: nv = (heads == 4'd1 || heads == 4'd2) ? WW_HEAD : WW_WIRE;
            default: nv = c_mid;
        endcase
        if (!ctrl.in_grid)
        begin
            nv = c_mid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_up)
        begin
            sh_up_reg <= rdata;
        end
        if (ctrl.load_mid)
        begin
            sh_mid_reg <= rdata;
        end
        if (ctrl.load_dn)
        begin
            sh_dn_reg <= rdata;
        end
        if (ctrl.shift)
        begin
            sh_up_reg    <= sh_up_reg  >> 2;
            sh_mid_reg   <= sh_mid_reg >> 2;
            sh_dn_reg    <= sh_dn_reg  >> 2;
            prev_up_reg  <= c_up;
            prev_mid_reg <= c_mid;
            prev_dn_reg  <= c_dn;
            out_reg      <= {nv, out_reg[ROW_BITS-1:2]};
        end
    end

    assign out_row = out_reg;

endmodule

FILE: rtl/wireworld_grid_step_core.sv
// wireworld grid core: item sequencer, configuration and result register
//
// input channel: in_valid/in_stall with kind, col, row, cell_value; one beat
// per item. output channel: out_valid/out_stall with read_value, done_kind,
// out_of_range; exactly one result beat per item, in order.
// config channel: cfg_valid/cfg_ready with cfg_index (0 width, 1 height)
// and cfg_data; always ready, other indexes are dropped.
// the grid sits in two banks of full-row words, one row per address.
// an in-range write or read goes through the row read, the modify and the result
// load; an out-of-range or unused kind goes straight to the result load.
// a step streams every row through a three-row window shifter at one cell
// per cycle: per row, the up, middle and down row reads, a shift for each of
// the 256 columns and a write-back, then the result is loaded at the end.
// one item is in work at a time; in_stall is high while it is.
// after reset the block clears both banks, one row per cycle, all 256 rows,
// with in_stall high; config writes are taken during that time.
// a result waiting under out_stall holds in the output register; the next
// item is still accepted and finishes up to its result, then waits.
module wireworld_grid_step_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     kind,
    input  logic [7:0]                     col,
    input  logic [7:0]                     row,
    input  logic [1:0]                     cell_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     read_value,
    output logic [1:0]                     done_kind,
    output logic                           out_of_range,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wwgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wwgs_pkg::CFG_W-1:0]     cfg_data
);
    import wwgs_pkg::*;

    function automatic logic [31:0] eff_size(input logic [CFG_W-1:0] v,
                                             input logic [31:0] lim);
        logic [31:0] r;
        r = 32'(v);
        if (v == '0)
        begin
            r = 32'd1;
        end
        else if (32'(v) > lim)
        begin
            r = lim;
        end
        return r;
    endfunction

    localparam logic [COL_W-1:0] X_LAST = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] Y_LAST = ROW_W'(MAX_HEIGHT - 1);

    state_t              state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [COL_W-1:0]    x_reg, x_next;
    logic [ROW_W-1:0]    y_reg, y_next;
    logic                cur_reg, cur_next;
    logic [WD_W-1:0]     w_reg, w_next;
    logic [HD_W-1:0]     h_reg, h_next;
    logic                out_valid_reg, out_valid_next;

    logic [1:0]          kind_reg, kind_next;
    logic [7:0]          col_reg, col_next;
    logic [7:0]          row_reg, row_next;
    logic [1:0]          val_reg, val_next;
    logic                oor_reg, oor_next;
    logic [1:0]          res_reg, res_next;
    logic [1:0]          read_value_reg, read_value_next;
    logic [1:0]          done_kind_reg, done_kind_next;
    logic                out_of_range_reg, out_of_range_next;

    mem_req_t            mem_req;
    logic [ROW_BITS-1:0] mem_wdata;
    logic [ROW_BITS-1:0] mem_rdata;
    eng_ctrl_t           eng_ctrl;
    logic [ROW_BITS-1:0] eng_row;

    logic [COL_W-1:0]    col_idx;
    logic [ROW_BITS-1:0] row_mod;
    logic [ROW_W-1:0]    y_up, y_dn;
    logic                y_in;
    logic                in_oor;
    logic                is_cell;

    wwgs_grid_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    wwgs_row_engine u_engine (
        .clk     (clk),
        .ctrl    (eng_ctrl),
        .rdata   (mem_rdata),
        .out_row (eng_row)
    );

    always_comb
    begin
        col_idx = COL_W'(col_reg);
        row_mod = mem_rdata;
        row_mod[{col_idx, 1'b0} +: 2] = val_reg;
        y_in = 32'(y_reg) < 32'(h_reg);
        y_up = (y_in && y_reg != '0) ? y_reg - 1'b1 : y_reg;
        y_dn = (y_in && (32'(y_reg) + 32'd1 < 32'(h_reg))) ? y_reg + 1'b1 : y_reg;
        is_cell = (kind == KIND_WRITE) || (kind == KIND_READ);
        in_oor = is_cell && ((32'(col) >= 32'(w_reg)) || (32'(row) >= 32'(h_reg)));
    end

    always_comb
    begin
        w_next = w_reg;
        h_next = h_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  w_next = WD_W'(eff_size(cfg_data, 32'(MAX_WIDTH)));
                CFG_GRID_HEIGHT: h_next = HD_W'(eff_size(cfg_data, 32'(MAX_HEIGHT)));
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        cur_next          = cur_reg;
        kind_next         = kind_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        val_next          = val_reg;
        oor_next          = oor_reg;
        res_next          = res_reg;
        read_value_next   = read_value_reg;
        done_kind_next    = done_kind_reg;
        out_of_range_next = out_of_range_reg;
        out_valid_next    = out_valid_reg && out_stall;
        mem_req           = '0;
        mem_req.rsel      = cur_reg;
        mem_wdata         = '0;
        eng_ctrl          = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 2'b11;
                mem_req.waddr = y_reg;
                if (y_reg == Y_LAST)
                begin
                    y_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    y_next = y_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    col_next  = col;
                    row_next  = row;
                    val_next  = cell_value;
                    oor_next  = in_oor;
                    res_next  = WW_BLANK;
                    if (kind == KIND_STEP)
                    begin
                        y_next     = '0;
                        phase_next = '0;
                        state_next = ST_STEP_RD;
                    end
                    else if (is_cell && !in_oor)
                    begin
                        state_next = ST_CELL_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CELL_RD:
            begin
                mem_req.raddr = ROW_W'(row_reg);
                state_next    = ST_CELL_MOD;
            end
            ST_CELL_MOD:
            begin
                if (kind_reg == KIND_WRITE)
                begin
                    mem_req.we[cur_reg] = 1'b1;
                    mem_req.waddr       = ROW_W'(row_reg);
                    mem_wdata           = row_mod;
                end
                else
                begin
                    res_next = mem_rdata[{col_idx, 1'b0} +: 2];
                end
                state_next = ST_DONE;
            end
            ST_STEP_RD:
            begin
                case (phase_reg)
                    2'd0:    mem_req.raddr = y_up;
                    2'd1:    mem_req.raddr = y_reg;
                    default: mem_req.raddr = y_dn;
                endcase
                eng_ctrl.load_up  = (phase_reg == 2'd1);
                eng_ctrl.load_mid = (phase_reg == 2'd2);
                eng_ctrl.load_dn  = (phase_reg == 2'd3);
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 2'd3)
                begin
                    x_next     = '0;
                    state_next = ST_STEP_SHIFT;
                end
            end
            ST_STEP_SHIFT:
            begin
                eng_ctrl.shift    = 1'b1;
                eng_ctrl.first    = (x_reg == '0);
                eng_ctrl.right_ok = (32'(x_reg) + 32'd1 < 32'(w_reg));
                eng_ctrl.in_grid  = y_in && (32'(x_reg) < 32'(w_reg));
                if (x_reg == X_LAST)
                begin
                    state_next = ST_STEP_WB;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            ST_STEP_WB:
            begin
                mem_req.we[~cur_reg] = 1'b1;
                mem_req.waddr        = y_reg;
                mem_wdata            = eng_row;
                if (y_reg == Y_LAST)
                begin
                    cur_next   = ~cur_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    y_next     = y_reg + 1'b1;
                    phase_next = '0;
                    state_next = ST_STEP_RD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    read_value_next   = res_reg;
                    done_kind_next    = kind_reg;
                    out_of_range_next = oor_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            cur_reg       <= 1'b0;
            w_reg         <= WD_W'(eff_size(CFG_W'(256), 32'(MAX_WIDTH)));
            h_reg         <= HD_W'(eff_size(CFG_W'(256), 32'(MAX_HEIGHT)));
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            cur_reg       <= cur_next;
            w_reg         <= w_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        col_reg          <= col_next;
        row_reg          <= row_next;
        val_reg          <= val_next;
        oor_reg          <= oor_next;
        res_reg          <= res_next;
        read_value_reg   <= read_value_next;
        done_kind_reg    <= done_kind_next;
        out_of_range_reg <= out_of_range_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign done_kind    = done_kind_reg;
    assign out_of_range = out_of_range_reg;

endmodule
